@@ rtl/core/ppsf_pkg.sv @@
// shared types and constants of the parallel port sample fifo
`default_nettype none

package ppsf_pkg;

  // operation codes carried in s_tuser
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // device port addresses
  localparam logic [15:0] PORT_DATA    = 16'h0378;
  localparam logic [15:0] PORT_STATUS  = 16'h0379;
  localparam logic [15:0] PORT_CONTROL = 16'h037A;

  // status and control bits
  localparam logic [7:0] STATUS_FULL = 8'h40;
  localparam logic [7:0] STROBE_MASK = 8'h04;

  // what one beat does to the device
  typedef struct packed {
    logic       handled;
    logic [7:0] read_data;
    logic       push;
    logic [7:0] push_data;
    logic       pop;
    logic       latch_wr;
    logic       ctrl_wr;
  } action_t;

endpackage

`default_nettype wire

@@ rtl/core/ppsf_decode.sv @@
// decode of one bus access or sample tick into device actions
`default_nettype none

module ppsf_decode (
  input  wire logic [1:0]       op,
  input  wire logic [15:0]      port,
  input  wire logic [7:0]       wdata,
  input  wire logic [7:0]       data_latch,
  input  wire logic [7:0]       last_control,
  input  wire logic             active,
  input  wire logic             full,
  input  wire logic             empty,
  output ppsf_pkg::action_t     act
);

  logic strobe_rise;

  // control bit 2 going from low to high
  assign strobe_rise = ((wdata & ppsf_pkg::STROBE_MASK) != 8'd0) &&
                       ((last_control & ppsf_pkg::STROBE_MASK) == 8'd0);

  always_comb begin
    act = '0;
    unique case (op)
      ppsf_pkg::OP_WRITE: begin
        if (port == ppsf_pkg::PORT_DATA) begin
          act.handled   = 1'b1;
          act.latch_wr  = 1'b1;
          act.push      = !full;
          act.push_data = wdata;
        end else if (port == ppsf_pkg::PORT_CONTROL) begin
          act.handled   = 1'b1;
          act.ctrl_wr   = 1'b1;
          act.push      = strobe_rise && !full;
          act.push_data = data_latch;
        end
      end
      ppsf_pkg::OP_READ: begin
        if (port == ppsf_pkg::PORT_STATUS) begin
          act.handled   = 1'b1;
          act.read_data = full ? ppsf_pkg::STATUS_FULL : 8'd0;
        end
      end
      ppsf_pkg::OP_TICK: begin
        act.pop = active && !empty;
      end
      default: begin
        act = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/ppsf_queue.sv @@
// circular sample buffer with registered head read
`default_nettype none

module ppsf_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [7:0] push_data,
  input  wire logic       pop,
  output logic            full,
  output logic            empty,
  output logic [7:0]      head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;

  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);

  // storage: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    if (pop) begin
      head_data <= mem[head];
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == LAST) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == LAST) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full buffer");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty buffer");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("fill count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("fill count did not advance on push");

endmodule

`default_nettype wire

@@ rtl/core/parallel_port_sample_fifo.sv @@
// parallel port sample fifo: bus access decode, sample buffer and result register
// the result beat of an accepted input beat is registered and presented in the cycle after it
// throughput: one beat per cycle while m_tready does not stall; the single result register and the buffer's
//   one write and one registered read per cycle set that figure
// reset (rst, synchronous): buffer emptied, data latch, control byte and
//   active cleared, no result pending; buffer contents are not cleared
`default_nettype none

module parallel_port_sample_fifo #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: active
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_wr_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [15:0] port, [23:16] wdata
  input  wire logic [1:0]  s_tuser,   // [1:0] op
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] read_data, [15:8] sample
  output logic [0:0]       m_tuser    // [0] handled
);

  logic              active;
  logic [7:0]        data_latch;
  logic [7:0]        last_control;
  logic              accept;
  logic              full;
  logic              empty;
  logic [7:0]        head_data;
  ppsf_pkg::action_t act;
  logic              handled;
  logic [7:0]        read_data;
  logic              popped;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cfg_wr_en) begin
      active <= cfg_wr_data[0];
    end
  end

  ppsf_decode u_decode (
    .op           (s_tuser),
    .port         (s_tdata[15:0]),
    .wdata        (s_tdata[23:16]),
    .data_latch   (data_latch),
    .last_control (last_control),
    .active       (active),
    .full         (full),
    .empty        (empty),
    .act          (act)
  );

  ppsf_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && act.push),
    .push_data (act.push_data),
    .pop       (accept && act.pop),
    .full      (full),
    .empty     (empty),
    .head_data (head_data)
  );

  // data latch and remembered control byte
  always_ff @(posedge clk) begin
    if (rst) begin
      data_latch   <= 8'd0;
      last_control <= 8'd0;
    end else if (accept) begin
      if (act.latch_wr) begin
        data_latch <= s_tdata[23:16];
      end
      if (act.ctrl_wr) begin
        last_control <= s_tdata[23:16];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      handled   <= act.handled;
      read_data <= act.read_data;
      popped    <= act.pop;
    end
  end

  assign m_tuser = handled;
  assign m_tdata = {popped ? head_data : 8'd0, read_data};

  a_pop_no_port: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && popped) |-> !handled)
    else $error("tick beat reported as port access");
  a_status_read: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && read_data != 8'd0) |-> (handled && read_data == ppsf_pkg::STATUS_FULL))
    else $error("bad status byte");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("stalled result changed");

endmodule

`default_nettype wire
